### sv/gpio_edge_interrupt_ports_core_assert.svh
// Assertion macros for the GPIO edge interrupt port block.
// Included by the checker; needs nothing else.
`ifndef GPIO_EDGE_INTERRUPT_PORTS_CORE_ASSERT_SVH
`define GPIO_EDGE_INTERRUPT_PORTS_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GEI_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define GEI_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/gei_pkg.sv
// Package for the GPIO edge interrupt port block: transaction types and codes.
// No dependencies.
`timescale 1ns / 1ps
package gei_pkg;

  localparam int LINE_COUNT = 48;
  localparam int EDGE_MAX   = 24;

  typedef logic [1:0]            opcode_t;
  typedef logic [3:0]            reg_addr_t;
  typedef logic [7:0]            byte_t;
  typedef logic [LINE_COUNT-1:0] lines_t;

  localparam opcode_t OP_READ   = 2'd0;
  localparam opcode_t OP_WRITE  = 2'd1;
  localparam opcode_t OP_SAMPLE = 2'd2;

  localparam reg_addr_t REG_PORT_FIRST  = 4'h0;
  localparam reg_addr_t REG_PORT_LAST   = 4'h5;
  localparam reg_addr_t REG_PENDING     = 4'h6;
  localparam reg_addr_t REG_PAGE_LOCK   = 4'h7;
  localparam reg_addr_t REG_PAGED_FIRST = 4'h8;
  localparam reg_addr_t REG_PAGED_LAST  = 4'hA;

  localparam logic [1:0] PAGE_POL  = 2'd1;
  localparam logic [1:0] PAGE_ENAB = 2'd2;
  localparam logic [1:0] PAGE_ID   = 2'd3;

  typedef struct packed {
    opcode_t   opcode;
    reg_addr_t reg_addr;
    byte_t     write_data;
    lines_t    pin_levels;
  } item_t;

  typedef struct packed {
    byte_t  read_data;
    lines_t pin_sink;
    logic   irq_out;
  } result_t;

endpackage

### sv/gei_item_if.sv
// Input channel interface: valid/ready handshake plus one request transaction.
// Depends on gei_pkg.
`timescale 1ns / 1ps
interface gei_item_if;
  logic               valid;
  logic               ready;
  gei_pkg::opcode_t   opcode;
  gei_pkg::reg_addr_t reg_addr;
  gei_pkg::byte_t     write_data;
  gei_pkg::lines_t    pin_levels;

  modport source (output valid, opcode, reg_addr, write_data, pin_levels, input ready);
  modport sink   (input valid, opcode, reg_addr, write_data, pin_levels, output ready);
endinterface

### sv/gei_result_if.sv
// Output channel interface: valid/ready handshake plus one result transaction.
// Depends on gei_pkg.
`timescale 1ns / 1ps
interface gei_result_if;
  logic            valid;
  logic            ready;
  gei_pkg::byte_t  read_data;
  gei_pkg::lines_t pin_sink;
  logic            irq_out;

  modport source (output valid, read_data, pin_sink, irq_out, input ready);
  modport sink   (input valid, read_data, pin_sink, irq_out, output ready);
endinterface

### sv/gei_in_stage.sv
// Input register: captures one request transaction per cycle while it is empty or the result register advances.
// Depends on gei_pkg and gei_item_if.
`timescale 1ns / 1ps
module gei_in_stage (
  input  logic           clk,
  input  logic           rst,
  gei_item_if.sink       item,
  input  logic           advance,
  output logic           stage_valid,
  output gei_pkg::item_t stage_item
);
  import gei_pkg::*;

  assign item.ready = !rst && (!stage_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item.ready) begin
      stage_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      stage_item <= '{opcode: item.opcode, reg_addr: item.reg_addr,
                      write_data: item.write_data, pin_levels: item.pin_levels};
    end
  end
endmodule

### sv/gei_regs.sv
// Register file and edge detector: decodes one transaction, updates state,
// forms the result from the updated state. Depends on gei_pkg.
`timescale 1ns / 1ps
module gei_regs #(
  parameter int PORT_COUNT = 6,
  parameter int EDGE_PORTS = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  gei_pkg::item_t   item,
  output gei_pkg::result_t next_result
);
  import gei_pkg::*;

  localparam int         EDGE_LINES = 8 * EDGE_PORTS;
  localparam logic [3:0] PORT_LIMIT = 4'(PORT_COUNT);
  localparam logic [1:0] EDGE_LIMIT = 2'(EDGE_PORTS);

  lines_t                sink_latch, sink_latch_next;
  logic [1:0]            page_select, page_select_next;
  logic [5:0]            port_lock, port_lock_next;
  logic [EDGE_LINES-1:0] edge_polarity, edge_polarity_next;
  logic [EDGE_LINES-1:0] edge_enable, edge_enable_next;
  logic [EDGE_LINES-1:0] edge_pending, edge_pending_next;
  logic [EDGE_LINES-1:0] last_edge_levels, last_edge_levels_next;

  logic [EDGE_LINES-1:0] now_levels, rise, fall, hit;
  logic [EDGE_MAX-1:0]   pol_w, en_w, pend_w, paged_view;
  logic [2:0]            port, flags;
  logic [1:0]            k;
  logic [5:0]            port_base;
  logic [4:0]            k_base;
  logic                  port_ok, paged_ok;
  byte_t                 rd;

  assign port      = item.reg_addr[2:0];
  assign k         = item.reg_addr[1:0];
  assign port_base = {port, 3'b000};
  assign k_base    = {k, 3'b000};
  assign port_ok   = item.reg_addr < PORT_LIMIT;
  assign paged_ok  = (page_select != 2'd0) && (k < EDGE_LIMIT);

  assign now_levels = item.pin_levels[EDGE_LINES-1:0];
  assign rise       = now_levels & ~last_edge_levels;
  assign fall       = ~now_levels & last_edge_levels;
  assign hit        = ((rise & edge_polarity) | (fall & ~edge_polarity)) & edge_enable;

  always_comb begin
    flags = '0;
    for (int p = 0; p < EDGE_PORTS; p++) begin
      flags[p] = |edge_pending[8*p +: 8];
    end
  end

  always_comb begin
    case (page_select)
      PAGE_POL:  paged_view = EDGE_MAX'(edge_polarity);
      PAGE_ENAB: paged_view = EDGE_MAX'(edge_enable);
      PAGE_ID:   paged_view = EDGE_MAX'(edge_pending);
      default:   paged_view = '0;
    endcase
  end

  always_comb begin
    rd                    = '0;
    sink_latch_next       = sink_latch;
    page_select_next      = page_select;
    port_lock_next        = port_lock;
    pol_w                 = EDGE_MAX'(edge_polarity);
    en_w                  = EDGE_MAX'(edge_enable);
    pend_w                = EDGE_MAX'(edge_pending);
    last_edge_levels_next = last_edge_levels;
    unique case (item.opcode)
      OP_READ: begin
        unique case (item.reg_addr) inside
          [REG_PORT_FIRST:REG_PORT_LAST]: begin
            if (port_ok) rd = ~item.pin_levels[port_base +: 8];
          end
          REG_PENDING:   rd = {5'b0, flags};
          REG_PAGE_LOCK: rd = {page_select, port_lock};
          [REG_PAGED_FIRST:REG_PAGED_LAST]: begin
            if (paged_ok) rd = paged_view[k_base +: 8];
          end
          default: rd = '0;
        endcase
      end
      OP_WRITE: begin
        unique case (item.reg_addr) inside
          [REG_PORT_FIRST:REG_PORT_LAST]: begin
            if (port_ok && !port_lock[port]) sink_latch_next[port_base +: 8] = item.write_data;
          end
          REG_PAGE_LOCK: begin
            page_select_next = item.write_data[7:6];
            port_lock_next   = item.write_data[5:0];
          end
          [REG_PAGED_FIRST:REG_PAGED_LAST]: begin
            if (paged_ok) begin
              case (page_select)
                PAGE_POL:  pol_w[k_base +: 8] = item.write_data;
                PAGE_ENAB: en_w[k_base +: 8]  = item.write_data;
                PAGE_ID:   pend_w[k_base +: 8] = pend_w[k_base +: 8] & item.write_data;
                default:   pol_w = EDGE_MAX'(edge_polarity);
              endcase
            end
          end
          default: rd = '0;
        endcase
      end
      OP_SAMPLE: begin
        pend_w                = EDGE_MAX'(edge_pending | hit);
        last_edge_levels_next = now_levels;
      end
      default: rd = '0;
    endcase
  end

  assign edge_polarity_next = pol_w[EDGE_LINES-1:0];
  assign edge_enable_next   = en_w[EDGE_LINES-1:0];
  assign edge_pending_next  = pend_w[EDGE_LINES-1:0];

  assign next_result = '{read_data: rd, pin_sink: sink_latch_next,
                         irq_out: |edge_pending_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      sink_latch       <= '0;
      page_select      <= '0;
      port_lock        <= '0;
      edge_polarity    <= '0;
      edge_enable      <= '0;
      edge_pending     <= '0;
      last_edge_levels <= '1;
    end else if (fire) begin
      sink_latch       <= sink_latch_next;
      page_select      <= page_select_next;
      port_lock        <= port_lock_next;
      edge_polarity    <= edge_polarity_next;
      edge_enable      <= edge_enable_next;
      edge_pending     <= edge_pending_next;
      last_edge_levels <= last_edge_levels_next;
    end
  end
endmodule

### sv/gei_out_stage.sv
// Result register: holds one result transaction until the sink takes it.
// Depends on gei_pkg and gei_result_if.
`timescale 1ns / 1ps
module gei_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             stage_valid,
  input  gei_pkg::result_t next_result,
  output logic             advance,
  gei_result_if.source     result
);
  import gei_pkg::*;

  result_t held;

  assign advance = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      held <= next_result;
    end
  end

  assign result.read_data = held.read_data;
  assign result.pin_sink  = held.pin_sink;
  assign result.irq_out   = held.irq_out;
endmodule

### sv/gpio_edge_interrupt_ports_core.sv
// Top level of the 48-line paged GPIO block with edge interrupts on lines 0..23.
// Depends on gei_pkg, gei_item_if, gei_result_if, gei_in_stage, gei_regs, gei_out_stage.
//
//   channel  dir  carries
//   item     in   opcode, reg_addr, write_data, pin_levels
//   result   out  read_data, pin_sink, irq_out
//
// One transaction per clock while the result side is not stalled.
// Input register, decode/update logic, result register: the logic between is combinational.
// Synchronous reset clears the pipeline, latches, page, locks and edge state;
// last pin levels reset to all ones.
// A stalled result holds; the input side keeps taking requests while a slot is free.
`timescale 1ns / 1ps
module gpio_edge_interrupt_ports_core #(
  parameter int PORT_COUNT = 6,
  parameter int EDGE_PORTS = 3
) (
  input logic          clk,
  input logic          rst,
  gei_item_if.sink     item,
  gei_result_if.source result
);
  import gei_pkg::*;

  logic    advance, stage_valid;
  item_t   stage_item;
  result_t next_result;

  gei_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  gei_regs #(
    .PORT_COUNT (PORT_COUNT),
    .EDGE_PORTS (EDGE_PORTS)
  ) u_regs (
    .clk         (clk),
    .rst         (rst),
    .fire        (stage_valid && advance),
    .item        (stage_item),
    .next_result (next_result)
  );

  gei_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .next_result (next_result),
    .advance     (advance),
    .result      (result)
  );
endmodule

### sv/gei_checker.sv
// Port-level checker for the GPIO edge interrupt block, bound to the top level.
// Depends on gei_item_if, gei_result_if and the assertion macro header.
`timescale 1ns / 1ps
`include "gpio_edge_interrupt_ports_core_assert.svh"
module gei_checker (
  input logic          clk,
  input logic          rst,
  gei_item_if.sink     item,
  gei_result_if.source result
);
  `GEI_ASSERT_NEXT(a_stall_hold, clk, rst, result.valid && !result.ready, result.valid && $stable(result.read_data) && $stable(result.pin_sink) && $stable(result.irq_out))
  `GEI_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !result.valid)
  `GEI_ASSERT_NOW(a_ready_flow, clk, rst, result.ready, item.ready)
  `GEI_ASSERT_NEXT(a_latency, clk, rst, item.valid && item.ready ##1 result.ready, result.valid)
endmodule

bind gpio_edge_interrupt_ports_core gei_checker u_chk (
  .clk    (clk),
  .rst    (rst),
  .item   (item),
  .result (result)
);

### tb/gpio_edge_interrupt_ports_core_tb.sv
// Testbench for gpio_edge_interrupt_ports_core: directed table, then random edge scenarios and noise bursts.
// Checks every result against an in-bench predictor; needs gei_pkg and the channel interfaces.
`timescale 1ns / 1ps
module gpio_edge_interrupt_ports_core_tb;
  import gei_pkg::*;

  localparam int PORT_COUNT = 6;
  localparam int EDGE_PORTS = 3;
  localparam logic [23:0] EDGE_MASK = 24'((64'd1 << (8 * EDGE_PORTS)) - 1);

  localparam opcode_t   OP_IDLE          = 2'd3;
  localparam reg_addr_t REG_PAGED_MID    = 4'h9;
  localparam reg_addr_t REG_UNUSED_FIRST = 4'hB;
  localparam reg_addr_t REG_UNUSED_LAST  = 4'hF;

  localparam int ROW_COUNT   = 25;
  localparam int ITEM_TARGET = 725;
  localparam int CALM_FIRST  = 300;
  localparam int CALM_LAST   = 450;
  localparam int HOLD_FIRST  = 200;
  localparam int HOLD_LAST   = 260;
  localparam int READY_CALM_FIRST = 500;
  localparam int READY_CALM_LAST  = 700;
  localparam int CYCLE_LIMIT = 50000;

  typedef struct {
    item_t it;
    bit    typed;
    byte_t typed_read;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gei_item_if   item_ch ();
  gei_result_if result_ch ();

  gpio_edge_interrupt_ports_core #(
    .PORT_COUNT(PORT_COUNT),
    .EDGE_PORTS(EDGE_PORTS)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted block state
  lines_t      sink_q;
  logic [1:0]  page_q;
  logic [5:0]  lock_q;
  logic [23:0] pol_q, en_q, pend_q, last_q;

  result_t   awaited_results [$];
  stim_row_t directed_rows [ROW_COUNT];
  lines_t    pins_now;

  int unsigned cycle_count, mismatches, results_checked, irq_results;
  int unsigned items_sent, n_reads, n_writes, n_samples, n_idles, hold_cycles;

  function automatic result_t apply_to_ports(item_t it);
    result_t     r;
    int          idx;
    int          k;
    logic [23:0] now_lv, rise, fall, hit;
    r.read_data = '0;
    idx = int'(it.reg_addr);
    k = idx - int'(REG_PAGED_FIRST);
    if (it.opcode == OP_READ) begin
      if (it.reg_addr <= REG_PORT_LAST) begin
        if (idx < PORT_COUNT) r.read_data = ~it.pin_levels[8*idx +: 8];
      end else if (it.reg_addr == REG_PENDING) begin
        for (int p = 0; p < 3; p++) r.read_data[p] = |(pend_q[8*p +: 8] & EDGE_MASK[8*p +: 8]);
      end else if (it.reg_addr == REG_PAGE_LOCK) begin
        r.read_data = {page_q, lock_q};
      end else if (it.reg_addr >= REG_PAGED_FIRST && it.reg_addr <= REG_PAGED_LAST) begin
        if (k < EDGE_PORTS) begin
          case (page_q)
            PAGE_POL:  r.read_data = pol_q[8*k +: 8];
            PAGE_ENAB: r.read_data = en_q[8*k +: 8];
            PAGE_ID:   r.read_data = pend_q[8*k +: 8];
            default:   r.read_data = '0;
          endcase
        end
      end
    end else if (it.opcode == OP_WRITE) begin
      if (it.reg_addr <= REG_PORT_LAST) begin
        if (idx < PORT_COUNT && !lock_q[idx]) sink_q[8*idx +: 8] = it.write_data;
      end else if (it.reg_addr == REG_PAGE_LOCK) begin
        page_q = it.write_data[7:6];
        lock_q = it.write_data[5:0];
      end else if (it.reg_addr >= REG_PAGED_FIRST && it.reg_addr <= REG_PAGED_LAST) begin
        if (k < EDGE_PORTS) begin
          case (page_q)
            PAGE_POL:  pol_q[8*k +: 8] = it.write_data;
            PAGE_ENAB: en_q[8*k +: 8] = it.write_data;
            PAGE_ID:   pend_q[8*k +: 8] = pend_q[8*k +: 8] & it.write_data;
            default:   ;
          endcase
          pol_q &= EDGE_MASK;
          en_q &= EDGE_MASK;
          pend_q &= EDGE_MASK;
        end
      end
    end else if (it.opcode == OP_SAMPLE) begin
      now_lv = it.pin_levels[23:0] & EDGE_MASK;
      rise = now_lv & ~last_q;
      fall = ~now_lv & last_q;
      hit = ((rise & pol_q) | (fall & ~pol_q)) & en_q & EDGE_MASK;
      pend_q = (pend_q | hit) & EDGE_MASK;
      last_q = (last_q & ~EDGE_MASK) | now_lv;
    end
    r.pin_sink = sink_q;
    r.irq_out = |(pend_q & EDGE_MASK);
    return r;
  endfunction

  function automatic stim_row_t row(opcode_t op, reg_addr_t a, byte_t d, lines_t p,
                                    bit t = 1'b0, byte_t rd = 8'h00);
    stim_row_t s;
    s.it.opcode = op;
    s.it.reg_addr = a;
    s.it.write_data = d;
    s.it.pin_levels = p;
    s.typed = t;
    s.typed_read = rd;
    return s;
  endfunction

  function automatic lines_t random_lines();
    lines_t v;
    v = {16'($urandom_range(65535)), 32'($urandom())};
    return v;
  endfunction

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch on %0s at result %0d: got %h, want %h", what, results_checked, got, want);
    mismatches++;
  endtask

  task automatic offer(input item_t it, input bit typed, input byte_t typed_rd);
    result_t want;
    if (!(items_sent >= CALM_FIRST && items_sent < CALM_LAST)) begin
      while ($urandom_range(99) < 14) begin
        item_ch.valid = 1'b0;
        @(negedge clk);
      end
    end
    item_ch.valid = 1'b1;
    item_ch.opcode = it.opcode;
    item_ch.reg_addr = it.reg_addr;
    item_ch.write_data = it.write_data;
    item_ch.pin_levels = it.pin_levels;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    want = apply_to_ports(it);
    if (typed) want.read_data = typed_rd;
    awaited_results.push_back(want);
    items_sent++;
    case (it.opcode)
      OP_READ:   n_reads++;
      OP_WRITE:  n_writes++;
      OP_SAMPLE: n_samples++;
      default:   n_idles++;
    endcase
    @(negedge clk);
  endtask

  task automatic send(opcode_t op, reg_addr_t a, byte_t d, lines_t p);
    item_t it;
    it.opcode = op;
    it.reg_addr = a;
    it.write_data = d;
    it.pin_levels = p;
    offer(it, 1'b0, 8'h00);
  endtask

  // program polarity and enables, toggle pins, then inspect and clear the latched edges
  task automatic run_edge_scenario();
    logic [5:0] lock;
    int         n;
    lock = ($urandom_range(3) == 0) ? 6'($urandom()) : 6'h00;
    send(OP_WRITE, REG_PAGE_LOCK, {PAGE_POL, lock}, random_lines());
    for (int k = 0; k < 3; k++)
      if ($urandom_range(1)) send(OP_WRITE, reg_addr_t'(REG_PAGED_FIRST + k), 8'($urandom()),
                                  random_lines());
    send(OP_WRITE, REG_PAGE_LOCK, {PAGE_ENAB, lock}, random_lines());
    for (int k = 0; k < 3; k++)
      if ($urandom_range(3) != 0) send(OP_WRITE, reg_addr_t'(REG_PAGED_FIRST + k),
                                       8'($urandom()), random_lines());
    send(OP_WRITE, reg_addr_t'($urandom_range(5)), 8'($urandom()), random_lines());
    n = $urandom_range(3, 10);
    for (int s = 0; s < n; s++) begin
      pins_now ^= {16'($urandom()), 8'($urandom()), 24'($urandom() & $urandom())};
      if ($urandom_range(9) == 0) pins_now = ~pins_now;
      send(OP_SAMPLE, reg_addr_t'($urandom()), 8'($urandom()), pins_now);
      if ($urandom_range(3) == 0)
        send(OP_READ, reg_addr_t'($urandom_range(5)), 8'($urandom()), pins_now);
    end
    send(OP_WRITE, REG_PAGE_LOCK, {PAGE_ID, lock}, random_lines());
    send(OP_READ, REG_PENDING, 8'($urandom()), random_lines());
    send(OP_READ, reg_addr_t'($urandom_range(REG_PAGED_FIRST, REG_PAGED_LAST)), 8'($urandom()),
         random_lines());
    send(OP_WRITE, reg_addr_t'($urandom_range(REG_PAGED_FIRST, REG_PAGED_LAST)),
         8'($urandom()), random_lines());
    send(OP_READ, REG_PENDING, 8'($urandom()), random_lines());
  endtask

  task automatic run_noise_burst();
    int n;
    n = $urandom_range(5, 15);
    for (int i = 0; i < n; i++)
      send(opcode_t'($urandom()), reg_addr_t'($urandom()), 8'($urandom()), random_lines());
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      results_checked++;
      if (result_ch.irq_out) irq_results++;
      if (awaited_results.size() == 0) begin
        flag_mismatch("unexpected result", {result_ch.read_data, result_ch.pin_sink}, 0);
      end else begin
        want = awaited_results.pop_front();
        if (result_ch.read_data !== want.read_data)
          flag_mismatch("read_data", result_ch.read_data, want.read_data);
        if (result_ch.pin_sink !== want.pin_sink)
          flag_mismatch("pin_sink", result_ch.pin_sink, want.pin_sink);
        if (result_ch.irq_out !== want.irq_out)
          flag_mismatch("irq_out", result_ch.irq_out, want.irq_out);
      end
    end
  end

  initial begin
    int unsigned rcv_cycle;
    rcv_cycle = 0;
    result_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      rcv_cycle++;
      if (rcv_cycle >= HOLD_FIRST && rcv_cycle < HOLD_LAST) begin
        result_ch.ready = 1'b0;
        hold_cycles++;
      end else if (rcv_cycle >= READY_CALM_FIRST && rcv_cycle < READY_CALM_LAST) begin
        result_ch.ready = 1'b1;
      end else begin
        result_ch.ready = ($urandom_range(99) >= 14);
      end
    end
  end

  initial begin
    item_ch.valid = 1'b0;
    item_ch.opcode = OP_READ;
    item_ch.reg_addr = '0;
    item_ch.write_data = '0;
    item_ch.pin_levels = '0;
    sink_q = '0;
    page_q = '0;
    lock_q = '0;
    pol_q = '0;
    en_q = '0;
    pend_q = '0;
    last_q = 24'hFFFFFF;
    pins_now = '1;

    directed_rows = '{
      row(OP_READ,   REG_PAGE_LOCK,    8'h00, '0, 1'b1, 8'h00),
      row(OP_READ,   REG_PENDING,      8'hFF, '0, 1'b1, 8'h00),
      row(OP_READ,   REG_PORT_FIRST,   8'h00, '0, 1'b1, 8'hFF),
      row(OP_READ,   REG_PORT_LAST,    8'h00, '1, 1'b1, 8'h00),
      row(OP_READ,   REG_UNUSED_LAST,  8'hFF, '1, 1'b1, 8'h00),
      row(OP_WRITE,  REG_PORT_FIRST,   8'hFF, '0),
      row(OP_WRITE,  REG_PORT_LAST,    8'hA5, '1),
      row(OP_WRITE,  REG_UNUSED_FIRST, 8'hFF, '0),
      row(OP_WRITE,  REG_PENDING,      8'hFF, '0),
      row(OP_WRITE,  REG_PAGED_FIRST,  8'hFF, '0),
      row(OP_READ,   REG_PAGED_FIRST,  8'h00, '0, 1'b1, 8'h00),
      row(OP_WRITE,  REG_PAGE_LOCK,    {PAGE_POL, 6'h01}, '0),
      row(OP_WRITE,  REG_PORT_FIRST,   8'h00, '0),
      row(OP_WRITE,  REG_PAGED_FIRST,  8'hFF, '0),
      row(OP_WRITE,  REG_PAGE_LOCK,    {PAGE_ENAB, 6'h00}, '0),
      row(OP_WRITE,  REG_PAGED_FIRST,  8'hFF, '0),
      row(OP_WRITE,  REG_PAGED_MID,    8'h0F, '0),
      row(OP_WRITE,  REG_PAGED_LAST,   8'hF0, '0),
      row(OP_SAMPLE, REG_PORT_FIRST,   8'h00, '0),
      row(OP_SAMPLE, REG_PORT_FIRST,   8'h00, '1),
      row(OP_WRITE,  REG_PAGE_LOCK,    {PAGE_ID, 6'h3F}, '0),
      row(OP_READ,   REG_PENDING,      8'h00, '0),
      row(OP_WRITE,  REG_PAGED_MID,    8'h00, '0),
      row(OP_READ,   REG_PAGED_LAST,   8'h00, '0),
      row(OP_IDLE,   REG_PAGE_LOCK,    8'hFF, 48'hA5A5_5A5A_F00F)
    };

    repeat (8) @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      offer(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].typed_read);

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(99) < 70) run_edge_scenario();
      else run_noise_burst();
    end
    item_ch.valid = 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d reads, %0d writes, %0d pin samples, %0d idle ops; %0d results checked",
             n_reads, n_writes, n_samples, n_idles, results_checked);
    $display("%0d results had the interrupt raised; output held off for %0d cycles",
             irq_results, hold_cycles);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
